@@ hw/rtl/lfu_pkg.sv @@
// Shared sizes and types for the LFU page replacement unit.
package lfu_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;
	localparam int COUNT_W   = 16;
	localparam int IDX_W     = $clog2(FRAMES);
	localparam int WAYS_W    = $clog2(FRAMES + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [WAYS_W-1:0]    ways_t;

	// Map a raw frame limit onto 1 .. FRAMES.
	function automatic ways_t clamp_ways(input logic [4:0] raw);
		ways_t w;
		w = WAYS_W'(FRAMES);
		if (raw == 5'd0) begin
			w = WAYS_W'(1);
		end else if ({27'd0, raw} < 32'(FRAMES)) begin
			w = WAYS_W'(raw);
		end
		return w;
	endfunction

endpackage

@@ hw/rtl/lfu_page_replacement_unit.sv @@
// Top level of the LFU page replacement unit: frame table, scan/shift sequencer, result register.

// One request is one page reference. The unit keeps up to 16 resident pages in
// a list packed at the front (position 0 is the most recent reference), each
// with a 16-bit use count that saturates. A hit moves the page to the front
// and bumps its count; a miss with a free frame pushes everything back one
// slot; a miss with all frames in use evicts the lowest count, ties going to
// the entry furthest back. Let W be the active frame count (ways_in_use
// clamped to 1..16) and S (0..15) the position of the entry that gets
// replaced or moved. One compare unit walks the W frames one per cycle, a
// pick step chooses the position to open, shift steps move the S entries in
// front of that position back by one, and a finish step writes the front
// entry and the result, waiting while the result register is full and
// out_stall is high. The next request is taken once the unit is idle again.
// in_stall is high from acceptance until the front entry is written; the
// result then sits in an output register so the next request can enter while
// the result waits. Write ways_in_use only while idle; entries beyond a
// reduced limit are kept and reappear when it grows.
module lfu_page_replacement_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ways_in_use_we,
	input  logic [4:0]                ways_in_use,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [lfu_pkg::PAGE_BITS-1:0] page_number,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      miss,
	output logic                      evicted_valid,
	output logic [15:0]               evicted_page
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_PICK   = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	// Frame table: page numbers need no reset, counts do (zero means empty).
	lfu_pkg::page_t  pages_q [lfu_pkg::FRAMES];
	lfu_pkg::count_t counts_q [lfu_pkg::FRAMES];

	logic [2:0]      state_q;
	logic [4:0]      cfg_ways_q;
	lfu_pkg::ways_t  ways_q;
	lfu_pkg::page_t  req_page_q;

	// Scan results.
	lfu_pkg::idx_t   idx_q;
	lfu_pkg::ways_t  used_q;
	logic            hit_q;
	lfu_pkg::idx_t   hit_at_q;
	lfu_pkg::count_t hit_count_q;
	logic            have_min_q;
	lfu_pkg::idx_t   min_at_q;
	lfu_pkg::count_t min_count_q;
	lfu_pkg::page_t  min_page_q;

	// Shift position, walks down to the front.
	lfu_pkg::idx_t   sh_q;

	// Result register.
	logic            out_valid_q;
	logic            miss_q;
	logic            evicted_valid_q;
	logic [15:0]     evicted_page_q;

	logic            in_take;
	logic            out_load;
	logic            scan_last;
	lfu_pkg::count_t scan_count;
	lfu_pkg::page_t  scan_page;
	logic            scan_take_min;
	logic            evict;
	lfu_pkg::idx_t   shift_start;
	lfu_pkg::count_t front_count;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	// The shared compare unit looks at one frame per cycle.
	assign scan_count    = counts_q[idx_q];
	assign scan_page     = pages_q[idx_q];
	assign scan_last     = ({1'b0, idx_q} == (ways_q - lfu_pkg::WAYS_W'(1)));
	assign scan_take_min = !have_min_q || (scan_count <= min_count_q);

	// Pick where the shift starts once the scan results have settled.
	assign evict = !hit_q && (used_q == ways_q);
	always_comb begin
		if (hit_q) begin
			shift_start = hit_at_q;
		end else if (evict) begin
			shift_start = min_at_q;
		end else begin
			shift_start = lfu_pkg::IDX_W'(used_q);
		end
	end

	// Hit: bump with saturation. Miss: start a fresh page at one.
	always_comb begin
		if (!hit_q) begin
			front_count = lfu_pkg::COUNT_W'(1);
		end else if (hit_count_q == lfu_pkg::COUNT_MAX) begin
			front_count = hit_count_q;
		end else begin
			front_count = hit_count_q + lfu_pkg::COUNT_W'(1);
		end
	end

	// Finish only when the result register is free or being drained.
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_ways_q  <= 5'd16;
			out_valid_q <= 1'b0;
			for (int i = 0; i < lfu_pkg::FRAMES; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			if (ways_in_use_we) begin
				cfg_ways_q <= ways_in_use;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (sh_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						// Move one entry back per cycle.
						counts_q[sh_q] <= counts_q[sh_q - lfu_pkg::IDX_W'(1)];
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						counts_q[0] <= front_count;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					req_page_q <= page_number;
					ways_q     <= lfu_pkg::clamp_ways(cfg_ways_q);
					idx_q      <= '0;
					used_q     <= '0;
					hit_q      <= 1'b0;
					have_min_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (scan_count != '0) begin
					used_q <= used_q + lfu_pkg::WAYS_W'(1);
					// Later copies override earlier ones: furthest back wins.
					if (scan_page == req_page_q) begin
						hit_q       <= 1'b1;
						hit_at_q    <= idx_q;
						hit_count_q <= scan_count;
					end
					if (scan_take_min) begin
						have_min_q  <= 1'b1;
						min_at_q    <= idx_q;
						min_count_q <= scan_count;
						min_page_q  <= scan_page;
					end
				end
				if (!scan_last) begin
					idx_q <= idx_q + lfu_pkg::IDX_W'(1);
				end
			end
			ST_SHIFT: begin
				if (sh_q != '0) begin
					pages_q[sh_q] <= pages_q[sh_q - lfu_pkg::IDX_W'(1)];
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					pages_q[0]      <= req_page_q;
					miss_q          <= !hit_q;
					evicted_valid_q <= evict;
					evicted_page_q  <= evict ? 16'(min_page_q) : 16'd0;
				end
			end
			default: begin
			end
		endcase
	end

	// Load the shift position once the scan has settled, then count down.
	always_ff @(posedge clk) begin
		if (state_q == ST_PICK) begin
			sh_q <= shift_start;
		end else if (state_q == ST_SHIFT && sh_q != '0) begin
			sh_q <= sh_q - lfu_pkg::IDX_W'(1);
		end else if (state_q == ST_IDLE) begin
			sh_q <= '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign miss          = miss_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;

	// An eviction only ever happens on a miss.
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!evicted_valid || miss))
		else $error("eviction reported without a miss");

	// The evicted page field is zero when nothing was evicted.
	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evicted_valid) |-> (evicted_page == 16'd0))
		else $error("evicted page nonzero with no eviction");

	// The scan never walks past the active frame count.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, idx_q} < ways_q))
		else $error("scan index beyond active frames");

	// After a request completes, the front entry is occupied.
	a_front_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (counts_q[0] != '0))
		else $error("front entry empty after update");

endmodule
